FILE: rtl/rtlw_pkg.sv
`timescale 1ns / 1ps

package rtlw_pkg;

  // Table geometry and position width
  localparam int MAX_RUNS  = 1024;
  localparam int RUN_IDX_W = $clog2(MAX_RUNS);
  localparam int RUN_CNT_W = RUN_IDX_W + 1;
  localparam int POS_W     = 32;
  localparam int HOP_W     = 16;
  localparam int KIND_W    = 2;

  localparam logic [HOP_W-1:0] HOP_LIMIT_RST = '1;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // One run table word: start, length and LF value side by side
  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] lf;
  } run_entry_t;

  // Walk sequencer
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_INIT = 7'b0000010,
    ST_HOP  = 7'b0000100,
    ST_SRCH = 7'b0001000,
    ST_CMP  = 7'b0010000,
    ST_CHK  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

endpackage

FILE: rtl/run_table_lf_walk.sv
`timescale 1ns / 1ps

// Run table with a bounded LF-mapping walk.
//
// Input channel (in_valid/in_ready): one item per transfer. An append item
// adds a run at the end of the table (ignored once the table is full), a
// clear item empties it, a query walks LF hops from start_run + offset.
// Append and clear complete in the transfer cycle and give no result; a
// query on an empty table or an unloaded run gives no result either.
// Result channel (out_valid/out_ready): one transfer per query carried out.
// Each hop of a query runs a binary search over the single table memory,
// one probe at a time (issue read in SRCH, compare in CMP) through its one
// read port. One query is walked at a time; in_ready is high again once
// the result sits in the output register.
// Stall: a finished result waits in the output register while out_ready is
// low; a second finished query holds in its last state until it drains.
// Config (cfg_valid/cfg_ready): hop_limit, always ready; write only while
// idle. Reset (rst_n low, synchronous) empties the table, sets hop_limit to
// 65535 and drops any pending result; the table memory is not cleared.

module run_table_lf_walk (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rtlw_pkg::KIND_W-1:0]         in_kind,
  input  logic [rtlw_pkg::POS_W-1:0]          in_run_len,
  input  logic [rtlw_pkg::POS_W-1:0]          in_run_lf_value,
  input  logic [rtlw_pkg::RUN_IDX_W-1:0]      in_start_run,
  input  logic [rtlw_pkg::POS_W-1:0]          in_block_offset,
  input  logic [rtlw_pkg::POS_W-1:0]          in_block_length,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rtlw_pkg::POS_W-1:0]          out_end_position,
  output logic [rtlw_pkg::HOP_W-1:0]          out_hop_count,
  output logic                                out_timed_out,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtlw_pkg::HOP_W-1:0]          cfg_hop_limit
);

  import rtlw_pkg::*;

  // Run table: one synchronous memory, one write and one read per cycle.
  // Writes happen only on an append in IDLE, reads only on a query accept or
  // during a walk, so the two never touch the same entry in the same cycle.
  run_entry_t mem [MAX_RUNS];
  run_entry_t rd_data_r;
  logic                 rd_en;
  logic [RUN_IDX_W-1:0] rd_addr;
  logic                 wr_en;
  run_entry_t           wr_data;

  state_t state_r;

  logic [RUN_CNT_W-1:0] runs_loaded_r;
  logic [POS_W-1:0]     next_start_r;
  logic [HOP_W-1:0]     hop_limit_r;

  // Walk registers
  logic [POS_W-1:0]     pos_r;
  logic [POS_W-1:0]     step_r;
  logic [POS_W-1:0]     boff_r;
  logic [POS_W-1:0]     blen_r;
  logic [HOP_W-1:0]     hops_r;
  logic [HOP_W-1:0]     limit_r;
  logic [RUN_IDX_W-1:0] lo_r;
  logic [RUN_IDX_W-1:0] hi_r;
  logic [RUN_IDX_W-1:0] mid_r;
  logic                 tmo_r;

  // Output register
  logic                 out_valid_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [HOP_W-1:0]     out_hops_r;
  logic                 out_tmo_r;

  logic                 in_xfer;
  logic                 query_ok;
  logic                 table_full;
  logic [RUN_CNT_W-1:0] mid_sum;
  logic [RUN_IDX_W-1:0] mid;
  logic [RUN_IDX_W-1:0] last_idx;
  logic [POS_W:0]       blk_end;
  logic [POS_W:0]       run_end;
  logic                 stop_hit;
  logic                 out_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_end_position = out_pos_r;
  assign out_hop_count    = out_hops_r;
  assign out_timed_out    = out_tmo_r;

  assign table_full = (runs_loaded_r == RUN_CNT_W'(MAX_RUNS));
  assign query_ok   = (runs_loaded_r != '0) && ({1'b0, in_start_run} < runs_loaded_r);
  assign last_idx   = RUN_IDX_W'(runs_loaded_r - RUN_CNT_W'(1));

  // Upper midpoint of the search window
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + RUN_CNT_W'(1);
  assign mid     = mid_sum[RUN_CNT_W-1:1];

  // Stop test (pos at a run start, or block past the run end), exact with one carry bit on each side
  assign blk_end  = {1'b0, pos_r} + {1'b0, blen_r};
  assign run_end  = {1'b0, rd_data_r.start} + {1'b0, rd_data_r.len};
  assign stop_hit = (pos_r == rd_data_r.start) || (blk_end > run_end);

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_start_run;
    case (state_r)
      ST_IDLE: begin
        rd_en = in_xfer && (kind_t'(in_kind) == KIND_QUERY) && query_ok;
      end
      ST_SRCH: begin
        rd_en   = 1'b1;
        rd_addr = (lo_r == hi_r) ? lo_r : mid;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en         = in_xfer && (kind_t'(in_kind) == KIND_APPEND) && !table_full;
  assign wr_data.start = next_start_r;
  assign wr_data.len   = in_run_len;
  assign wr_data.lf    = in_run_lf_value;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[runs_loaded_r[RUN_IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_limit_r <= HOP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      hop_limit_r <= cfg_hop_limit;
    end
  end

  // Table bookkeeping: append advances, clear empties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_loaded_r <= '0;
      next_start_r  <= '0;
    end else if (in_xfer) begin
      case (kind_t'(in_kind))
        KIND_APPEND: begin
          if (!table_full) begin
            runs_loaded_r <= runs_loaded_r + RUN_CNT_W'(1);
            next_start_r  <= next_start_r + in_run_len;
          end
        end
        KIND_CLEAR: begin
          runs_loaded_r <= '0;
          next_start_r  <= '0;
        end
        default: begin
          runs_loaded_r <= runs_loaded_r;
        end
      endcase
    end
  end

  // Walk sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          // capture the query; its start run is being read
          if (rd_en) begin
            state_r <= ST_INIT;
          end
        end
        ST_INIT: begin
          state_r <= ST_HOP;
        end
        ST_HOP: begin
          state_r <= ST_SRCH;
        end
        ST_SRCH: begin
          state_r <= (lo_r == hi_r) ? ST_CHK : ST_CMP;
        end
        ST_CMP: begin
          state_r <= ST_SRCH;
        end
        ST_CHK: begin
          if (stop_hit || (hops_r >= limit_r)) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_HOP;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        boff_r  <= in_block_offset;
        blen_r  <= in_block_length;
        hops_r  <= '0;
        limit_r <= (hop_limit_r == '0) ? HOP_W'(1) : hop_limit_r;
      end
      ST_INIT: begin
        pos_r  <= rd_data_r.start + boff_r;
        step_r <= rd_data_r.lf - rd_data_r.start;
      end
      ST_HOP: begin
        pos_r  <= pos_r + step_r;
        hops_r <= hops_r + HOP_W'(1);
        lo_r   <= '0;
        hi_r   <= last_idx;
      end
      ST_SRCH: begin
        mid_r <= mid;
      end
      ST_CMP: begin
        // narrow toward the last run whose start is not above pos
        if (pos_r < rd_data_r.start) begin
          hi_r <= mid_r - RUN_IDX_W'(1);
        end else begin
          lo_r <= mid_r;
        end
      end
      ST_CHK: begin
        step_r <= rd_data_r.lf - rd_data_r.start;
        tmo_r  <= !stop_hit;
      end
      default: begin
        pos_r <= pos_r;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r  <= pos_r;
      out_hops_r <= hops_r;
      out_tmo_r  <= tmo_r;
    end
  end

  // Checks
  a_runs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    runs_loaded_r <= RUN_CNT_W'(MAX_RUNS))
    else $error("runs loaded beyond table depth");

  a_hops_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK) |-> (hops_r != '0) && (hops_r <= limit_r))
    else $error("hop count outside 1..limit at stop check");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (lo_r <= hi_r) && ({1'b0, hi_r} < runs_loaded_r))
    else $error("search window out of range");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the finish state");

endmodule
